### rtl/rte_pkg.sv
package rte_pkg;

    localparam int MATCH_DEPTH = 64;
    localparam int GROUP_COUNT = 10;
    localparam int QUEUE_DEPTH = 2;

    localparam int ADDR_W = (MATCH_DEPTH > 1) ? $clog2(MATCH_DEPTH) : 1;
    localparam int CNT_W  = $clog2(MATCH_DEPTH + 1);
    localparam int GIDX_W = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // template characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_UP_L   = 8'h4C;
    localparam logic [7:0] CH_UP_U   = 8'h55;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_L   = 8'h6C;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_U   = 8'h75;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CASE_DIFF = 8'h20;

    typedef enum logic [1:0] {
        FN_START    = 2'd0,
        FN_WR_BYTE  = 2'd1,
        FN_WR_GROUP = 2'd2,
        FN_TEMPLATE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CASE_NONE = 2'd0,
        CASE_UP   = 2'd1,
        CASE_DOWN = 2'd2
    } case_t;

    typedef enum logic [2:0] {
        OP_START       = 3'd0,
        OP_WR_BYTE     = 3'd1,
        OP_WR_GROUP    = 3'd2,
        OP_EMIT_CONV   = 3'd3,
        OP_EMIT_RAW    = 3'd4,
        OP_SET_STICKY  = 3'd5,
        OP_SET_ONESHOT = 3'd6,
        OP_COPY        = 3'd7
    } op_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_COPY = 1'b1
    } back_state_t;

    typedef struct packed {
        op_t          op;
        logic [7:0]   data;
        logic [5:0]   addr;
        logic [3:0]   group;
        logic [5:0]   offset;
        logic [6:0]   length;
        logic         present;
        case_t        dir;
    } cmd_t;

    function automatic logic [7:0] case_convert(input logic [7:0] c,
                                                input case_t one_shot,
                                                input case_t sticky);
        case_t      dir;
        logic [7:0] r;
        dir = (one_shot != CASE_NONE) ? one_shot : sticky;
        r   = c;
        if (dir == CASE_DOWN && c >= CH_UP_A && c <= CH_UP_Z) begin
            r = c + CASE_DIFF;
        end else if (dir == CASE_UP && c >= CH_LO_A && c <= CH_LO_Z) begin
            r = c - CASE_DIFF;
        end
        return r;
    endfunction

endpackage

### rtl/rte_ram.sv
module rte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/rte_front.sv
module rte_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_func,
    input  logic [7:0]        s_char_value,
    input  logic [5:0]        s_position,
    input  logic [3:0]        s_group_index,
    input  logic [5:0]        s_group_offset,
    input  logic [6:0]        s_group_length,
    input  logic              s_group_present,
    input  logic              q_full,
    output logic              push,
    output rte_pkg::cmd_t     push_cmd
);

    logic          esc_reg;
    logic          esc_next;
    logic          has_op;
    logic          accept;
    rte_pkg::cmd_t cmd;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && has_op;
    assign push_cmd = cmd;

    always_comb begin
        cmd.op      = rte_pkg::OP_START;
        cmd.data    = s_char_value;
        cmd.addr    = s_position;
        cmd.group   = s_group_index;
        cmd.offset  = s_group_offset;
        cmd.length  = s_group_length;
        cmd.present = s_group_present;
        cmd.dir     = rte_pkg::CASE_NONE;
        has_op      = 1'b1;
        esc_next    = esc_reg;
        unique case (rte_pkg::func_t'(s_func))
            rte_pkg::FN_START: begin
                cmd.op   = rte_pkg::OP_START;
                esc_next = 1'b0;
            end
            rte_pkg::FN_WR_BYTE: begin
                cmd.op = rte_pkg::OP_WR_BYTE;
                has_op = 7'(s_position) < 7'(rte_pkg::MATCH_DEPTH);
            end
            rte_pkg::FN_WR_GROUP: begin
                cmd.op = rte_pkg::OP_WR_GROUP;
                has_op = s_group_index < 4'(rte_pkg::GROUP_COUNT);
            end
            rte_pkg::FN_TEMPLATE: begin
                if (esc_reg) begin
                    esc_next = 1'b0;
                    if (s_char_value >= rte_pkg::CH_ZERO && s_char_value <= rte_pkg::CH_NINE)
                    begin
                        cmd.op    = rte_pkg::OP_COPY;
                        cmd.group = 4'(s_char_value - rte_pkg::CH_ZERO);
                    end else begin
                        cmd.op = rte_pkg::OP_EMIT_RAW;
                        unique case (s_char_value)
                            rte_pkg::CH_UP_U: begin
                                cmd.op  = rte_pkg::OP_SET_STICKY;
                                cmd.dir = rte_pkg::CASE_UP;
                            end
                            rte_pkg::CH_UP_L: begin
                                cmd.op  = rte_pkg::OP_SET_STICKY;
                                cmd.dir = rte_pkg::CASE_DOWN;
                            end
                            rte_pkg::CH_UP_E, rte_pkg::CH_LO_E: begin
                                cmd.op  = rte_pkg::OP_SET_STICKY;
                                cmd.dir = rte_pkg::CASE_NONE;
                            end
                            rte_pkg::CH_LO_U: begin
                                cmd.op  = rte_pkg::OP_SET_ONESHOT;
                                cmd.dir = rte_pkg::CASE_UP;
                            end
                            rte_pkg::CH_LO_L: begin
                                cmd.op  = rte_pkg::OP_SET_ONESHOT;
                                cmd.dir = rte_pkg::CASE_DOWN;
                            end
                            rte_pkg::CH_LO_B: cmd.data = rte_pkg::CH_BS;
                            rte_pkg::CH_LO_F: cmd.data = rte_pkg::CH_FF;
                            rte_pkg::CH_LO_R: cmd.data = rte_pkg::CH_CR;
                            rte_pkg::CH_LO_T: cmd.data = rte_pkg::CH_TAB;
                            rte_pkg::CH_LO_N: cmd.data = rte_pkg::CH_LF;
                            default: cmd.data = s_char_value;
                        endcase
                    end
                end else if (s_char_value == rte_pkg::CH_BSLASH) begin
                    esc_next = 1'b1;
                    has_op   = 1'b0;
                end else if (s_char_value == rte_pkg::CH_AMP) begin
                    cmd.op    = rte_pkg::OP_COPY;
                    cmd.group = 4'd0;
                end else if (s_char_value == rte_pkg::CH_LF || s_char_value == rte_pkg::CH_CR)
                begin
                    cmd.op   = rte_pkg::OP_EMIT_RAW;
                    cmd.data = rte_pkg::CH_LF;
                end else begin
                    cmd.op = rte_pkg::OP_EMIT_CONV;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg <= 1'b0;
        end else if (accept) begin
            esc_reg <= esc_next;
        end
    end

endmodule

### rtl/rte_queue.sv
module rte_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  rte_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output rte_pkg::cmd_t q_cmd
);

    rte_pkg::cmd_t                  mem_reg [rte_pkg::QUEUE_DEPTH];
    logic [rte_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [rte_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [rte_pkg::QCNT_W-1:0]     count_reg;
    logic [rte_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [rte_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [rte_pkg::QCNT_W-1:0]     count_next;

    assign full    = count_reg == rte_pkg::QCNT_W'(rte_pkg::QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_cmd   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == rte_pkg::QPTR_W'(rte_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == rte_pkg::QPTR_W'(rte_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_valid)
        else $error("command queue read while empty");

endmodule

### rtl/rte_back.sv
module rte_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  rte_pkg::cmd_t q_cmd,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_byte,
    output logic          m_status,
    output logic          m_last_of_run
);

    localparam int AW = rte_pkg::ADDR_W;
    localparam int CW = rte_pkg::CNT_W;
    localparam int GC = rte_pkg::GROUP_COUNT;

    rte_pkg::back_state_t state_reg, state_next;

    logic [5:0]    grp_start_reg [GC];
    logic [5:0]    grp_start_next [GC];
    logic [6:0]    grp_size_reg [GC];
    logic [6:0]    grp_size_next [GC];
    logic [GC-1:0] grp_valid_reg, grp_valid_next;

    rte_pkg::case_t one_shot_reg, one_shot_next;
    rte_pkg::case_t sticky_reg, sticky_next;
    logic           aborted_reg, aborted_next;

    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [CW-1:0] rd_left_reg, rd_left_next;
    logic [CW-1:0] out_left_reg, out_left_next;
    logic          data_vld_reg, data_vld_next;

    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_byte_reg, m_byte_next;
    logic          m_status_reg, m_status_next;
    logic          m_last_reg, m_last_next;

    logic                 can_out;
    logic [rte_pkg::GIDX_W-1:0] gi;
    logic                 g_ok;
    logic [5:0]           g_off;
    logic [6:0]           g_len;
    logic [6:0]           avail;
    logic [CW-1:0]        eff_len;
    logic                 needs_out;
    logic                 idle_go;
    logic                 start_copy;
    logic                 consume;
    logic                 issue;
    logic                 copy_done;
    logic                 ram_we;
    logic                 ram_re;
    logic [7:0]           ram_rdata;
    logic                 case_active;

    rte_ram #(
        .WIDTH (8),
        .DEPTH (rte_pkg::MATCH_DEPTH)
    ) u_match_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (q_cmd.addr[AW-1:0]),
        .wdata (q_cmd.data),
        .re    (ram_re),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    assign can_out = !m_valid_reg || m_ready;

    // group lookup and clipping against the store
    assign gi    = q_cmd.group[rte_pkg::GIDX_W-1:0];
    assign g_ok  = (q_cmd.group < 4'(GC)) && grp_valid_reg[gi];
    assign g_off = grp_start_reg[gi];
    assign g_len = grp_size_reg[gi];
    assign avail = 7'(rte_pkg::MATCH_DEPTH) - 7'(g_off);

    always_comb begin
        if (!g_ok || 7'(g_off) >= 7'(rte_pkg::MATCH_DEPTH)) begin
            eff_len = '0;
        end else if (g_len > avail) begin
            eff_len = CW'(avail);
        end else begin
            eff_len = CW'(g_len);
        end
    end

    assign needs_out = (q_cmd.op == rte_pkg::OP_EMIT_CONV || q_cmd.op == rte_pkg::OP_EMIT_RAW)
                       && !aborted_reg;
    assign idle_go    = (state_reg == rte_pkg::BK_IDLE) && q_valid && (!needs_out || can_out);
    assign pop        = idle_go;
    assign start_copy = idle_go && q_cmd.op == rte_pkg::OP_COPY && !aborted_reg
                        && eff_len != '0;

    assign consume   = (state_reg == rte_pkg::BK_COPY) && data_vld_reg && can_out;
    assign issue     = (state_reg == rte_pkg::BK_COPY) && rd_left_reg != '0
                       && (!data_vld_reg || consume);
    assign copy_done = consume && (ram_rdata == rte_pkg::CH_NUL || out_left_reg == CW'(1));
    assign ram_re    = issue;
    assign case_active = one_shot_reg != rte_pkg::CASE_NONE || sticky_reg != rte_pkg::CASE_NONE;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rte_pkg::BK_IDLE: begin
                if (start_copy) begin
                    state_next = rte_pkg::BK_COPY;
                end
            end
            rte_pkg::BK_COPY: begin
                if (copy_done) begin
                    state_next = rte_pkg::BK_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        grp_start_next = grp_start_reg;
        grp_size_next  = grp_size_reg;
        grp_valid_next = grp_valid_reg;
        one_shot_next  = one_shot_reg;
        sticky_next    = sticky_reg;
        aborted_next   = aborted_reg;
        rd_addr_next   = rd_addr_reg;
        rd_left_next   = rd_left_reg;
        out_left_next  = out_left_reg;
        data_vld_next  = data_vld_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_byte_next    = m_byte_reg;
        m_status_next  = m_status_reg;
        m_last_next    = m_last_reg;
        ram_we         = 1'b0;
        unique case (state_reg)
            rte_pkg::BK_IDLE: begin
                if (idle_go) begin
                    unique case (q_cmd.op)
                        rte_pkg::OP_START: begin
                            one_shot_next = rte_pkg::CASE_NONE;
                            sticky_next   = rte_pkg::CASE_NONE;
                            aborted_next  = 1'b0;
                        end
                        rte_pkg::OP_WR_BYTE: begin
                            ram_we = 1'b1;
                        end
                        rte_pkg::OP_WR_GROUP: begin
                            grp_start_next[gi] = q_cmd.offset;
                            grp_size_next[gi]  = q_cmd.length;
                            grp_valid_next[gi] = q_cmd.present;
                        end
                        rte_pkg::OP_EMIT_CONV: begin
                            if (!aborted_reg) begin
                                m_valid_next  = 1'b1;
                                m_byte_next   = rte_pkg::case_convert(q_cmd.data,
                                                                     one_shot_reg, sticky_reg);
                                m_status_next = 1'b0;
                                m_last_next   = 1'b1;
                                if (case_active) begin
                                    one_shot_next = rte_pkg::CASE_NONE;
                                end
                            end
                        end
                        rte_pkg::OP_EMIT_RAW: begin
                            if (!aborted_reg) begin
                                m_valid_next  = 1'b1;
                                m_byte_next   = q_cmd.data;
                                m_status_next = 1'b0;
                                m_last_next   = 1'b1;
                            end
                        end
                        rte_pkg::OP_SET_STICKY: begin
                            if (!aborted_reg) begin
                                sticky_next = q_cmd.dir;
                            end
                        end
                        rte_pkg::OP_SET_ONESHOT: begin
                            if (!aborted_reg) begin
                                one_shot_next = q_cmd.dir;
                            end
                        end
                        rte_pkg::OP_COPY: begin
                            if (start_copy) begin
                                rd_addr_next  = g_off[AW-1:0];
                                rd_left_next  = eff_len;
                                out_left_next = eff_len;
                                data_vld_next = 1'b0;
                            end
                        end
                    endcase
                end
            end
            rte_pkg::BK_COPY: begin
                if (issue) begin
                    rd_addr_next = rd_addr_reg + 1'b1;
                    rd_left_next = rd_left_reg - 1'b1;
                end
                data_vld_next = issue || (data_vld_reg && !consume);
                if (consume) begin
                    m_valid_next = 1'b1;
                    if (ram_rdata == rte_pkg::CH_NUL) begin
                        // bad byte in group ends the whole expansion
                        m_byte_next   = 8'h00;
                        m_status_next = 1'b1;
                        m_last_next   = 1'b1;
                        aborted_next  = 1'b1;
                        data_vld_next = 1'b0;
                    end else begin
                        m_status_next = 1'b0;
                        m_last_next   = out_left_reg == CW'(1);
                        out_left_next = out_left_reg - 1'b1;
                        if (ram_rdata == rte_pkg::CH_LF) begin
                            m_byte_next = rte_pkg::CH_LF;
                        end else begin
                            m_byte_next = rte_pkg::case_convert(ram_rdata,
                                                               one_shot_reg, sticky_reg);
                            if (case_active) begin
                                one_shot_next = rte_pkg::CASE_NONE;
                            end
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rte_pkg::BK_IDLE;
            grp_start_reg <= '{default: '0};
            grp_size_reg  <= '{default: '0};
            grp_valid_reg <= '0;
            one_shot_reg  <= rte_pkg::CASE_NONE;
            sticky_reg    <= rte_pkg::CASE_NONE;
            aborted_reg   <= 1'b0;
            rd_left_reg   <= '0;
            out_left_reg  <= '0;
            data_vld_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            grp_start_reg <= grp_start_next;
            grp_size_reg  <= grp_size_next;
            grp_valid_reg <= grp_valid_next;
            one_shot_reg  <= one_shot_next;
            sticky_reg    <= sticky_next;
            aborted_reg   <= aborted_next;
            rd_left_reg   <= rd_left_next;
            out_left_reg  <= out_left_next;
            data_vld_reg  <= data_vld_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg  <= rd_addr_next;
        m_byte_reg   <= m_byte_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_byte_reg;
    assign m_status      = m_status_reg;
    assign m_last_of_run = m_last_reg;

    a_copy_not_aborted: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rte_pkg::BK_COPY) |-> !aborted_reg)
        else $error("group copy running after abort");

    a_copy_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rte_pkg::BK_COPY) |->
        ((CW+1)'(out_left_reg) == (CW+1)'(rd_left_reg) + (CW+1)'(data_vld_reg)))
        else $error("copy read and output counts out of step");

    a_copy_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rte_pkg::BK_COPY) |-> out_left_reg != '0)
        else $error("copy running with nothing left to send");

    a_error_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg) |-> (m_last_reg && m_byte_reg == 8'h00))
        else $error("error word not final or not zero");

endmodule

### rtl/replacement_template_expander.sv
// replacement template expander
// input channel s_*: one word per command. s_func selects start, match byte
// write, group bounds write or template character; the other fields carry
// that command's operands. load the match bytes and group bounds, issue a
// start, then stream the template characters.
// result channel m_*: one expanded byte per word; m_last_of_run marks the
// final word caused by one input word, m_status flags a NUL met in a group.
// a front decoder handles escapes and feeds a two-word command queue; the
// back end executes commands and owns the match store and case state.
// a plain character passes through the command queue and the output
// register to m_*; a group copy enters the copy state and then gives
// one byte per cycle while the receiver is ready, paced by the match
// store's registered read. throughput: one word per cycle on both sides
// while the receiver is ready; a group copy holds the queue while it runs.
// reset clears group bounds, case state, pending escape and abort flag; the
// match store is not cleared and must be written before use.
// a stalled receiver holds the output register; the queue then fills and
// s_ready drops after two more words.
module replacement_template_expander (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [7:0] s_char_value,
    input  logic [5:0] s_position,
    input  logic [3:0] s_group_index,
    input  logic [5:0] s_group_offset,
    input  logic [6:0] s_group_length,
    input  logic       s_group_present,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_status,
    output logic       m_last_of_run
);

    logic          push;
    rte_pkg::cmd_t push_cmd;
    logic          q_full;
    logic          pop;
    logic          q_valid;
    rte_pkg::cmd_t q_cmd;

    rte_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_char_value    (s_char_value),
        .s_position      (s_position),
        .s_group_index   (s_group_index),
        .s_group_offset  (s_group_offset),
        .s_group_length  (s_group_length),
        .s_group_present (s_group_present),
        .q_full          (q_full),
        .push            (push),
        .push_cmd        (push_cmd)
    );

    rte_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    rte_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_status      (m_status),
        .m_last_of_run (m_last_of_run)
    );

endmodule
